// ===== rtl/pec15_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PEC15 checksum package
// Shared types, constants and the CRC-15 lookup function.
// ----------------------------------------------------------------------------
package pec15_pkg;

  localparam logic [15:0] PEC_SEED = 16'h0010;
  localparam logic [15:0] PEC_POLY = 16'h4599;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] check;
  } pec15_entry_t;

  typedef enum logic [2:0] {
    PH_ECHO = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } pec15_phase_t;

  // Table entry for one index: eight CRC-15 shift steps over the index.
  function automatic logic [15:0] pec15_table_entry(input logic [7:0] idx);
    logic [15:0] r;
    r = {1'b0, idx, 7'b0};
    for (int b = 0; b < 8; b++) begin
      if (r[14]) begin
        r = {r[14:0], 1'b0} ^ PEC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/pec15_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PEC15 input channel
// Valid/ready channel carrying one payload byte and its last-byte marker.
// ----------------------------------------------------------------------------
interface pec15_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source(output valid, output data_byte, output frame_last, input ready);
  modport sink(input valid, input data_byte, input frame_last, output ready);
endinterface

// ===== rtl/pec15_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PEC15 result channel
// Valid/ready channel carrying one echoed or checksum byte with its flags.
// ----------------------------------------------------------------------------
interface pec15_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_check;
  logic       frame_end;

  modport source(output valid, output out_byte, output is_check, output frame_end,
                 input ready);
  modport sink(input valid, input out_byte, input is_check, input frame_end,
               output ready);
endinterface

// ===== rtl/pec15_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PEC15 front end
// Accepts payload bytes, updates the running remainder and queues each byte
// with its last marker and, for a last byte, the finished checksum word.
// ----------------------------------------------------------------------------
module pec15_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_frame_last,
  input  logic                    q_full,
  output logic                    q_push,
  output pec15_pkg::pec15_entry_t q_wdata
);

  logic [15:0] rem_r;
  logic [15:0] rem_nxt;
  logic [7:0]  idx;
  logic [15:0] rem_upd;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign idx     = rem_r[14:7] ^ in_data_byte;
  assign rem_upd = {rem_r[7:0], 8'h00} ^ pec15_pkg::pec15_table_entry(idx);

  always_comb begin
    rem_nxt = rem_r;
    if (q_push) begin
      rem_nxt = in_frame_last ? pec15_pkg::PEC_SEED : rem_upd;
    end
  end

  assign q_wdata.data  = in_data_byte;
  assign q_wdata.last  = in_frame_last;
  assign q_wdata.check = {rem_upd[14:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= pec15_pkg::PEC_SEED;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== rtl/pec15_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PEC15 queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module pec15_queue #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  pec15_pkg::pec15_entry_t wdata,
  output logic                    full,
  input  logic                    pop,
  output logic                    valid,
  output pec15_pkg::pec15_entry_t rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  pec15_pkg::pec15_entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          do_pop;

  assign full   = (cnt_r == FULL_CNT);
  assign valid  = (cnt_r != '0);
  assign rdata  = mem[rd_ptr_r];
  assign do_pop = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/pec15_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PEC15 back end
// Turns each queued byte into its echo and, after a last byte, the two
// checksum bytes, through a registered output stage.
// ----------------------------------------------------------------------------
module pec15_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  pec15_pkg::pec15_entry_t q_rdata,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_is_check,
  output logic                    out_frame_end
);

  pec15_pkg::pec15_phase_t phase_r;
  pec15_pkg::pec15_phase_t phase_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       check_r;
  logic       check_nxt;
  logic       end_r;
  logic       end_nxt;
  logic       load;
  logic       emit;

  assign load = !out_valid_r || out_ready;
  assign emit = load && q_valid;

  always_comb begin
    phase_nxt     = phase_r;
    byte_nxt      = byte_r;
    check_nxt     = check_r;
    end_nxt       = end_r;
    q_pop         = 1'b0;
    out_valid_nxt = load ? emit : out_valid_r;
    if (emit) begin
      case (phase_r)
        pec15_pkg::PH_ECHO: begin
          byte_nxt  = q_rdata.data;
          check_nxt = 1'b0;
          end_nxt   = 1'b0;
          q_pop     = !q_rdata.last;
          phase_nxt = q_rdata.last ? pec15_pkg::PH_HIGH : pec15_pkg::PH_ECHO;
        end
        pec15_pkg::PH_HIGH: begin
          byte_nxt  = q_rdata.check[15:8];
          check_nxt = 1'b1;
          end_nxt   = 1'b0;
          phase_nxt = pec15_pkg::PH_LOW;
        end
        pec15_pkg::PH_LOW: begin
          byte_nxt  = q_rdata.check[7:0];
          check_nxt = 1'b1;
          end_nxt   = 1'b1;
          q_pop     = 1'b1;
          phase_nxt = pec15_pkg::PH_ECHO;
        end
        default: begin
          byte_nxt  = q_rdata.data;
          check_nxt = 1'b0;
          end_nxt   = 1'b0;
          phase_nxt = pec15_pkg::PH_ECHO;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pec15_pkg::PH_ECHO;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    check_r <= check_nxt;
    end_r   <= end_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = byte_r;
  assign out_is_check  = check_r;
  assign out_frame_end = end_r;

  // The sequencer phase always holds exactly one code.
  assert property (@(posedge clk) disable iff (!rst_n) $onehot(phase_r))
    else $error("pec15_back: phase register is not one-hot");

  // A frame end is only ever flagged on a checksum byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && end_r |-> check_r)
    else $error("pec15_back: frame end on a payload echo");

  // The checksum phases work on a last byte still held at the queue head.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == pec15_pkg::PH_HIGH) || (phase_r == pec15_pkg::PH_LOW)
      |-> q_valid && q_rdata.last)
    else $error("pec15_back: checksum phase without a queued last byte");

  // The high checksum byte is always followed by the low one.
  assert property (@(posedge clk) disable iff (!rst_n)
    emit && (phase_r == pec15_pkg::PH_HIGH) |=> phase_r == pec15_pkg::PH_LOW)
    else $error("pec15_back: high checksum byte not followed by low byte");

endmodule

// ===== rtl/pec15_frame_checksum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PEC15 frame checksum
// CRC-15 (polynomial 0x4599, seed 16) over frames of payload bytes.
// ----------------------------------------------------------------------------
// The input channel takes one payload byte per item with a marker on the
// last byte of a frame. The result channel echoes every payload byte and,
// after a last byte, gives the two checksum bytes (remainder shifted left by
// one), high byte first; the low byte carries the frame end flag.
// Each echo passes through the queue and the output register. The front end
// takes one item per cycle, limited only by the queue; the output register
// sends one result per cycle unless the receiver stalls, so a frame of N bytes
// gives N + 2 results. The remainder takes one table lookup and XOR per byte.
// When the receiver stalls, the output register holds its result and the
// queue of QUEUE_DEPTH items fills; input ready drops once it is full.
// Reset clears the queue and the output stage and reseeds the remainder.
// ----------------------------------------------------------------------------
module pec15_frame_checksum #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  pec15_in_if.sink   in_ch,
  pec15_out_if.source out_ch
);

  pec15_pkg::pec15_entry_t q_wdata;
  pec15_pkg::pec15_entry_t q_rdata;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;

  pec15_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data_byte  (in_ch.data_byte),
    .in_frame_last (in_ch.frame_last),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  pec15_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  pec15_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_byte      (out_ch.out_byte),
    .out_is_check  (out_ch.is_check),
    .out_frame_end (out_ch.frame_end)
  );

endmodule
